// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define ASSERT_ON_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== sv/bec_pkg.sv =====
package bec_pkg;

  localparam int ACTION_W         = 2;
  localparam int MASK_W           = 6;
  localparam int KEY_W            = 8;
  localparam int WAIT_W           = 4;
  localparam int MAX_BUTTONS      = 8;
  localparam int BIT_IDX_W        = 3;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int BUTTON_COUNT_DEF = 6;

  localparam logic [ACTION_W-1:0] ACT_POLL  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] CMD_POLL     = 2'd0;
  localparam logic [1:0] CMD_POLL_POP = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  typedef struct packed {
    logic [1:0]             kind;
    logic [MAX_BUTTONS-1:0] push_mask;
  } bec_cmd_t;

  function automatic logic [KEY_W-1:0] key_code_of(input logic [BIT_IDX_W-1:0] idx);
    logic [KEY_W-1:0] code;
    case (idx)
      3'd0: code = 8'hB5;
      3'd1: code = 8'hB6;
      3'd2: code = 8'hB7;
      3'd3: code = 8'hB4;
      3'd4: code = 8'h0D;
      3'd5: code = 8'hB1;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/button_edge_key_fifo_top.sv =====
// A poll word passes from the front end through a two-entry command queue to the back end,
// which writes one key per cycle for each new press into the key store and then, for a pop,
// reads the pop slot; a clear or an unused action code skips both. The back end takes one word
// at a time, and the command queue holds up to two more words while it works.
// Reset is synchronous and active low; it empties the ring, clears the previous mask,
// disables polling and drops any pending result. The key store itself is not cleared.
module button_edge_key_fifo_top #(
  parameter int QUEUE_DEPTH  = bec_pkg::QUEUE_DEPTH_DEF,
  parameter int BUTTON_COUNT = bec_pkg::BUTTON_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bec_pkg::ACTION_W-1:0] in_action,
  input  logic [bec_pkg::MASK_W-1:0]   in_button_mask,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_key_valid,
  output logic [bec_pkg::KEY_W-1:0]   out_key_code,
  output logic [bec_pkg::WAIT_W-1:0]  out_keys_waiting
);
  import bec_pkg::*;

  logic     fq_valid, fq_ready, bq_valid, bq_ready;
  bec_cmd_t fq_cmd, bq_cmd;

  bec_front #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_button_mask (in_button_mask),
    .cmd_valid      (fq_valid),
    .cmd_ready      (fq_ready),
    .cmd            (fq_cmd)
  );

  bec_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_cmd),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_cmd)
  );

  bec_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (bq_valid),
    .cmd_ready        (bq_ready),
    .cmd              (bq_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code),
    .out_keys_waiting (out_keys_waiting)
  );

endmodule

// ===== sv/bec_ram.sv =====
module bec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bec_front.sv =====
module bec_front #(
  parameter int BUTTON_COUNT = bec_pkg::BUTTON_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bec_pkg::ACTION_W-1:0]  in_action,
  input  logic [bec_pkg::MASK_W-1:0]    in_button_mask,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output bec_pkg::bec_cmd_t             cmd
);
  import bec_pkg::*;

  logic                    enabled_r;
  logic [BUTTON_COUNT-1:0] prev_r, prev_nxt;
  logic [MAX_BUTTONS-1:0]  levels;
  logic [BUTTON_COUNT-1:0] now;
  logic [MAX_BUTTONS-1:0]  rising_ext;
  logic                    is_poll;
  logic                    accept;

  assign levels   = MAX_BUTTONS'(in_button_mask);
  assign now      = levels[BUTTON_COUNT-1:0];
  assign in_ready = cmd_ready;
  assign accept   = in_valid && cmd_ready;
  assign cmd_valid = in_valid;

  always_comb begin
    rising_ext = '0;
    rising_ext[BUTTON_COUNT-1:0] = now & ~prev_r;
    case (in_action)
      ACT_POLL:  cmd.kind = CMD_POLL;
      ACT_POP:   cmd.kind = CMD_POLL_POP;
      ACT_CLEAR: cmd.kind = CMD_CLEAR;
      default:   cmd.kind = CMD_NONE;
    endcase
    is_poll = (cmd.kind == CMD_POLL) || (cmd.kind == CMD_POLL_POP);
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      cmd.push_mask[i] = is_poll && enabled_r && rising_ext[i] &&
                         (key_code_of(BIT_IDX_W'(i)) != '0);
    end
    prev_nxt = prev_r;
    if (accept) begin
      if (is_poll && enabled_r) begin
        prev_nxt = now;
      end else if (cmd.kind == CMD_CLEAR) begin
        prev_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      prev_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        enabled_r <= cfg_wr_data;
      end
      prev_r <= prev_nxt;
    end
  end

endmodule

// ===== sv/bec_cmd_fifo.sv =====
module bec_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  bec_pkg::bec_cmd_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output bec_pkg::bec_cmd_t rd_data
);
  import bec_pkg::*;

  bec_cmd_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/bec_back.sv =====
module bec_back #(
  parameter int QUEUE_DEPTH = bec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  bec_pkg::bec_cmd_t           cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_key_valid,
  output logic [bec_pkg::KEY_W-1:0]   out_key_code,
  output logic [bec_pkg::WAIT_W-1:0]  out_keys_waiting
);
  import bec_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W = (CNT_W > WAIT_W) ? CNT_W : WAIT_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUSH = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [1:0]             kind_r, kind_nxt;
  logic [MAX_BUTTONS-1:0] mask_r, mask_nxt;
  logic [PTR_W-1:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic                   hit_r, hit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_key_valid_r;
  logic [KEY_W-1:0]       out_key_code_r;
  logic [WAIT_W-1:0]      out_keys_waiting_r;
  logic                   load_out;
  logic [BIT_IDX_W-1:0]   low_idx;
  logic [PTR_W-1:0]       wp_next, rp_next;
  logic [EXT_W-1:0]       count;
  logic [WAIT_W-1:0]      waiting;
  logic                   ram_we, ram_re;
  logic [KEY_W-1:0]       ram_rdata;

  assign wp_next = (wp_r == LAST) ? '0 : wp_r + 1'b1;
  assign rp_next = (rp_r == LAST) ? '0 : rp_r + 1'b1;

  always_comb begin
    low_idx = '0;
    for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_idx = BIT_IDX_W'(i);
      end
    end
    if (wp_r >= rp_r) begin
      count = EXT_W'(wp_r - rp_r);
    end else begin
      count = EXT_W'(wp_r) + EXT_W'(QUEUE_DEPTH) - EXT_W'(rp_r);
    end
    waiting = (count > EXT_W'(15)) ? WAIT_W'(15) : count[WAIT_W-1:0];
  end

  bec_ram #(
    .WIDTH (KEY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (key_code_of(low_idx)),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign cmd_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    mask_nxt  = mask_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    hit_nxt   = hit_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          kind_nxt = cmd.kind;
          mask_nxt = cmd.push_mask;
          hit_nxt  = 1'b0;
          if (cmd.kind == CMD_CLEAR) begin
            wp_nxt    = '0;
            rp_nxt    = '0;
            state_nxt = S_FIN;
          end else if (cmd.kind == CMD_NONE) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (mask_r != '0) begin
          ram_we   = 1'b1;
          wp_nxt   = wp_next;
          mask_nxt = mask_r & (mask_r - 1'b1);
          if (wp_next == rp_r) begin
            rp_nxt = rp_next;
          end
        end else begin
          if ((kind_r == CMD_POLL_POP) && (wp_r != rp_r)) begin
            ram_re  = 1'b1;
            rp_nxt  = rp_next;
            hit_nxt = 1'b1;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    mask_r <= mask_nxt;
    hit_r  <= hit_nxt;
    if (load_out) begin
      out_key_valid_r    <= hit_r;
      out_key_code_r     <= hit_r ? ram_rdata : '0;
      out_keys_waiting_r <= waiting;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_valid    = out_key_valid_r;
  assign out_key_code     = out_key_code_r;
  assign out_keys_waiting = out_keys_waiting_r;

endmodule

// ===== sv/bec_checker.sv =====
`include "assert_macros.svh"

module bec_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         cfg_wr_en,
  input logic                         cfg_wr_data,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [bec_pkg::ACTION_W-1:0] in_action,
  input logic [bec_pkg::MASK_W-1:0]   in_button_mask,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_key_valid,
  input logic [bec_pkg::KEY_W-1:0]    out_key_code,
  input logic [bec_pkg::WAIT_W-1:0]   out_keys_waiting
);

  `ASSERT_ON_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_key_code) && $stable(out_keys_waiting))
  `ASSERT_ON_CLK(a_no_key_zero, clk, rst_n, out_valid && !out_key_valid |-> out_key_code == '0)
  `ASSERT_ON_CLK(a_key_nonzero, clk, rst_n, out_valid && out_key_valid |-> out_key_code != '0)
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)

endmodule

bind button_edge_key_fifo_top bec_checker u_bec_checker (.*);

// ===== tb/button_edge_key_fifo_top_test.sv =====
`timescale 1ns / 100ps

module button_edge_key_fifo_top_test;
  import bec_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [KEY_W-1:0] CODE_UP    = 8'hB5;
  localparam logic [KEY_W-1:0] CODE_DOWN  = 8'hB6;
  localparam logic [KEY_W-1:0] CODE_RIGHT = 8'hB7;
  localparam logic [KEY_W-1:0] CODE_LEFT  = 8'hB4;
  localparam logic [KEY_W-1:0] CODE_OK    = 8'h0D;
  localparam logic [KEY_W-1:0] CODE_BACK  = 8'hB1;

  localparam int IDLE_LIMIT      = 1000;
  localparam int PHASES          = 10;
  localparam int WORDS_PER_PHASE = 115;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [MASK_W-1:0]   mask;
  } poll_word_t;

  typedef struct packed {
    logic              key_valid;
    logic [KEY_W-1:0]  key_code;
    logic [WAIT_W-1:0] keys_waiting;
  } key_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] in_action = '0;
  logic [MASK_W-1:0]   in_button_mask = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_key_valid;
  logic [KEY_W-1:0]    out_key_code;
  logic [WAIT_W-1:0]   out_keys_waiting;

  poll_word_t  poll_words[$];
  key_result_t expected_results[$];
  poll_word_t  next_word;

  logic [KEY_W-1:0]  ring_keys [16];
  logic [WAIT_W-1:0] ring_wr = '0;
  logic [WAIT_W-1:0] ring_rd = '0;
  logic [MASK_W-1:0] last_mask = '0;
  logic              enabled_copy = 1'b0;

  logic send_idle_on = 1'b0;
  logic recv_idle_on = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   stall_cycles = 0;

  int errors = 0;
  int words_accepted = 0;
  int results_checked = 0;
  int keys_popped = 0;
  int keys_dropped = 0;
  int clears_seen = 0;

  button_edge_key_fifo_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_button_mask   (in_button_mask),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code),
    .out_keys_waiting (out_keys_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [KEY_W-1:0] key_for_button(input int button);
    logic [KEY_W-1:0] code;
    case (button)
      0: code = CODE_UP;
      1: code = CODE_DOWN;
      2: code = CODE_RIGHT;
      3: code = CODE_LEFT;
      4: code = CODE_OK;
      default: code = CODE_BACK;
    endcase
    return code;
  endfunction

  task automatic sample_buttons(input logic [MASK_W-1:0] mask);
    logic [MASK_W-1:0] rising;
    rising = mask & ~last_mask;
    if (enabled_copy) begin
      last_mask = mask;
      for (int i = 0; i < MASK_W; i++) begin
        if (rising[i]) begin
          if (ring_wr + 4'd1 == ring_rd) begin
            ring_rd = ring_rd + 4'd1;
            keys_dropped++;
          end
          ring_keys[ring_wr] = key_for_button(i);
          ring_wr = ring_wr + 4'd1;
        end
      end
    end
  endtask

  task automatic predict_result(input logic [ACTION_W-1:0] action,
                                input logic [MASK_W-1:0] mask);
    key_result_t r;
    r = '0;
    case (action)
      ACT_POLL: begin
        sample_buttons(mask);
      end
      ACT_POP: begin
        sample_buttons(mask);
        if (ring_wr != ring_rd) begin
          r.key_valid = 1'b1;
          r.key_code = ring_keys[ring_rd];
          ring_rd = ring_rd + 4'd1;
          keys_popped++;
        end
      end
      ACT_CLEAR: begin
        ring_wr = '0;
        ring_rd = '0;
        last_mask = '0;
        clears_seen++;
      end
      default: begin
      end
    endcase
    r.keys_waiting = ring_wr - ring_rd;
    expected_results.push_back(r);
  endtask

  task automatic check_result(input key_result_t got);
    key_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result word with nothing expected: key_valid %0d key_code %02h waiting %0d",
               $time, got.key_valid, got.key_code, got.keys_waiting);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (got.key_valid !== want.key_valid) begin
      $display("%0t: key_valid expected %0d actual %0d", $time, want.key_valid, got.key_valid);
      errors++;
    end
    if (got.key_code !== want.key_code) begin
      $display("%0t: key_code expected %02h actual %02h", $time, want.key_code, got.key_code);
      errors++;
    end
    if (got.keys_waiting !== want.keys_waiting) begin
      $display("%0t: keys_waiting expected %0d actual %0d", $time, want.keys_waiting,
               got.keys_waiting);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_result(in_action, in_button_mask);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (poll_words.size() > 0) begin
          next_word = poll_words.pop_front();
          in_valid <= 1'b1;
          in_action <= next_word.action;
          in_button_mask <= next_word.mask;
          if (send_idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 15);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result({out_key_valid, out_key_code, out_keys_waiting});
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("button_edge_key_fifo_top_test failed");
        $finish;
      end
    end
  end

  task automatic queue_word(input logic [ACTION_W-1:0] action, input logic [MASK_W-1:0] mask);
    poll_word_t w;
    w.action = action;
    w.mask = mask;
    poll_words.push_back(w);
  endtask

  task automatic wait_for_drain();
    while (poll_words.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_enable(input logic value);
    wait_for_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    enabled_copy = value;
  endtask

  // Each stretch of twenty words leans toward filling the ring, draining it, or a mix.
  task automatic queue_random_words(input int count);
    int pop_odds;
    int pick;
    logic [MASK_W-1:0] mask;
    pop_odds = 35;
    for (int n = 0; n < count; n++) begin
      if (n % 20 == 0) begin
        pop_odds = $urandom_range(0, 2) * 30 + 5;
      end
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0) begin
        mask = '0;
      end else begin
        mask = MASK_W'($urandom_range(0, 63));
      end
      if (pick < 3) begin
        queue_word(ACT_CLEAR, mask);
      end else if (pick < 6) begin
        queue_word(ACT_UNUSED, mask);
      end else if ($urandom_range(0, 99) < pop_odds) begin
        queue_word(ACT_POP, mask);
      end else begin
        queue_word(ACT_POLL, mask);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_enable(1'b0);
    queue_word(ACT_POLL, 6'h3F);
    queue_word(ACT_POP, 6'h3F);
    queue_word(ACT_CLEAR, 6'h3F);
    queue_word(ACT_UNUSED, 6'h2A);

    // Three full presses overfill the ring, then a single press walks across the buttons.
    set_enable(1'b1);
    queue_word(ACT_POLL, 6'h3F);
    queue_word(ACT_POP, 6'h3F);
    queue_word(ACT_POLL, 6'h00);
    queue_word(ACT_POLL, 6'h3F);
    queue_word(ACT_POLL, 6'h00);
    queue_word(ACT_POLL, 6'h3F);
    queue_word(ACT_POP, 6'h01);
    queue_word(ACT_UNUSED, 6'h15);
    queue_word(ACT_CLEAR, 6'h3F);
    queue_word(ACT_POP, 6'h00);
    for (int i = 0; i < MASK_W; i++) begin
      queue_word(ACT_POP, 6'h01 << i);
    end
    queue_word(ACT_POLL, 6'h2A);

    set_enable(1'b0);
    queue_word(ACT_POP, 6'h3F);
    queue_word(ACT_POLL, 6'h15);
    queue_word(ACT_CLEAR, 6'h00);

    for (int phase = 0; phase < PHASES; phase++) begin
      set_enable(phase % 4 != 3);
      send_idle_on = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
      recv_idle_on = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
      queue_random_words(WORDS_PER_PHASE);
    end

    wait_for_drain();
    repeat (20) @(posedge clk);

    $display("Checked %0d result words for %0d accepted words across both enable settings.",
             results_checked, words_accepted);
    $display("The run popped %0d keys, dropped %0d keys on overflow and saw %0d clears.",
             keys_popped, keys_dropped, clears_seen);
    if (errors == 0) begin
      $display("button_edge_key_fifo_top_test passed");
    end else begin
      $display("button_edge_key_fifo_top_test failed");
    end
    $finish;
  end

endmodule
